### src/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// shared constants and sequencer state type for the divisor sum unit
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int WIDTH_DEFAULT = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_ADD_D,
        ST_ADD_Q,
        ST_FINISH
    } state_t;

endpackage

### src/divisor_sum_unit.sv
// ----------------------------------------------------------------------------
// divisor_sum_unit
// sum of all positive divisors of each request, by trial division to sqrt(n)
// ----------------------------------------------------------------------------
// each request: a trial division for each d from 1 to floor(sqrt(n)) + 1, an add of d
// and of n / d for each divisor pair found, then the result load; n = 0 goes straight to the load
// requests: one at a time; the next request can be taken in the cycle after
// the result is loaded
// reset: asynchronous, clears the sequencer and the output valid
module divisor_sum_unit #(
    parameter int WIDTH = dsu_pkg::WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [8*((WIDTH+7)/8)-1:0]       s_axis_tdata,  // number
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [8*((WIDTH+3+7)/8)-1:0]     m_axis_tdata   // divisor_total
);

    localparam int OW  = WIDTH + 3;
    localparam int OBW = 8 * ((OW + 7) / 8);

    dsu_pkg::state_t state_reg, state_next;

    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [OW-1:0]    total_reg, total_next;
    logic [OW-1:0]    out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             div_start;
    logic             div_done;
    logic [WIDTH-1:0] div_quo;
    logic [WIDTH-1:0] div_rem;
    logic             load_out;
    logic             accept;

    dsu_div #(.WIDTH(WIDTH)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            dsu_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            dsu_pkg::ST_START:  div_start = 1'b1;
            dsu_pkg::ST_FINISH: load_out = !out_valid_reg || m_axis_tready;
            default:            ;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsu_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (s_axis_tdata[WIDTH-1:0] == '0) ? dsu_pkg::ST_FINISH
                                                                 : dsu_pkg::ST_START;
            end
            dsu_pkg::ST_START:
                state_next = dsu_pkg::ST_WAIT;
            dsu_pkg::ST_WAIT:
            begin
                if (div_done)
                begin
                    if (d_reg > div_quo)
                        state_next = dsu_pkg::ST_FINISH;
                    else if (div_rem == '0)
                        state_next = dsu_pkg::ST_ADD_D;
                    else
                        state_next = dsu_pkg::ST_START;
                end
            end
            dsu_pkg::ST_ADD_D:
                state_next = dsu_pkg::ST_ADD_Q;
            dsu_pkg::ST_ADD_Q:
                state_next = dsu_pkg::ST_START;
            dsu_pkg::ST_FINISH:
            begin
                if (load_out)
                    state_next = dsu_pkg::ST_IDLE;
            end
            default:
                state_next = dsu_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        n_next         = n_reg;
        d_next         = d_reg;
        total_next     = total_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            n_next     = s_axis_tdata[WIDTH-1:0];
            d_next     = WIDTH'(1);
            total_next = '0;
        end
        if (state_reg == dsu_pkg::ST_WAIT && div_done && d_reg <= div_quo
            && div_rem != '0)
            d_next = d_reg + WIDTH'(1);
        if (state_reg == dsu_pkg::ST_ADD_D)
            total_next = total_reg + {3'b000, d_reg};
        if (state_reg == dsu_pkg::ST_ADD_Q)
        begin
            // the square root divisor counts once
            if (div_quo != d_reg)
                total_next = total_reg + {3'b000, div_quo};
            d_next = d_reg + WIDTH'(1);
        end
        if (load_out)
        begin
            out_next       = total_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        total_reg <= total_next;
        out_reg   <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OBW - OW){1'b0}}, out_reg};

    a_add_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsu_pkg::ST_ADD_D) |-> (div_rem == '0 && d_reg <= div_quo))
        else $error("adding a trial value that does not divide");

    a_d_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsu_pkg::ST_START || state_reg == dsu_pkg::ST_WAIT) |-> (d_reg != '0))
        else $error("trial divisor is zero");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == dsu_pkg::ST_FINISH))
        else $error("result shown without finishing");

endmodule

### src/dsu_div.sv
// ----------------------------------------------------------------------------
// dsu_div
// restoring divider, one quotient bit per cycle, dividend shifted in msb first
// ----------------------------------------------------------------------------
module dsu_div #(
    parameter int WIDTH = dsu_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] div_reg, div_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;
    logic             last;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};
    assign last  = cnt_reg == CW'(WIDTH - 1);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");

    a_done_rem: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule
